FILE: rtl/vbi_pkg.sv
// Shared types and constants for the volume border index block.
// Holds the beat payload structs, the border mode codes and the register map.
// No dependencies.
package vbi_pkg;

  localparam int COORD_W   = 16;
  localparam int INDEX_W   = 30;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    MODE_CLAMP  = 2'd0,
    MODE_MIRROR = 2'd1,
    MODE_WRAP   = 2'd2,
    MODE_UNSUP  = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_MODE = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] slice_coord;
    logic signed [COORD_W-1:0] row_coord;
    logic signed [COORD_W-1:0] col_coord;
  } coord_t;

  typedef struct packed {
    logic [INDEX_W-1:0] linear_index;
    logic               fault;
  } result_t;

endpackage

FILE: rtl/volume_border_index.sv
// Border handling and linear addressing for a 3D volume: clamp, mirror or wrap per axis.
// Pipeline: axis prep, the wrap remainder chain, select, multiply and sum; the wrap remainder chain
// resolves four coordinate bits per stage and sets the depth.
// Throughput: one beat per cycle while out_ready is high; a held result lets new beats enter until the stages fill.
// Reset clears all valid bits and loads extents of 1 and clamp mode.
// Depends on vbi_pkg, vbi_axis_prep, vbi_mod_stage and vbi_index.
module volume_border_index #(
  parameter int MAX_EXTENT = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vbi_pkg::coord_t                 in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vbi_pkg::result_t                out_data,
  input  logic                            cfg_wr_en,
  input  logic [vbi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vbi_pkg::CFG_W-1:0]       cfg_wr_data
);

  localparam int EXT_W  = $clog2(MAX_EXTENT + 1);
  localparam int IDX_W  = $clog2(MAX_EXTENT);
  localparam int AREA_W = 2 * EXT_W;
  localparam int STEP   = 4;
  localparam int NSTG   = (COORD_BITS + STEP - 1) / STEP;
  localparam int PAD_W  = NSTG * STEP;
  localparam int SIDE_W = IDX_W + 2;
  localparam int NST    = NSTG + 4;
  localparam int CMP_W  = (EXT_W > vbi_pkg::CFG_W) ? EXT_W : vbi_pkg::CFG_W;
  localparam int S_SEL  = NSTG + 1;
  localparam int S_MUL  = NSTG + 2;
  localparam int S_SUM  = NSTG + 3;

  logic [vbi_pkg::CFG_W-1:0] extent_x, extent_y, extent_z;
  vbi_pkg::mode_t            border_mode;
  logic [EXT_W-1:0]          ext_ax [3];
  logic [AREA_W-1:0]         area;

  logic [NST-1:0] vld, en;

  logic [vbi_pkg::COORD_W-1:0] raw_ax [3];
  logic [COORD_BITS-1:0]       prep_mag [3];
  logic                        prep_neg [3];
  logic [IDX_W-1:0]            prep_alt [3];
  logic                        prep_fault [3];

  logic [EXT_W-1:0]  rem_s  [3][NSTG+1];
  logic [PAD_W-1:0]  mag_s  [3][NSTG+1];
  logic [SIDE_W-1:0] side_s [3][NSTG+1];

  logic [IDX_W-1:0] sel_val [3];
  logic [IDX_W-1:0] sel_c   [3];
  logic             sel_f;
  logic [EXT_W-1:0] diff    [3];

  function automatic logic [EXT_W-1:0] eff_extent(input logic [vbi_pkg::CFG_W-1:0] v);
    logic [CMP_W-1:0] x;
    logic [CMP_W-1:0] e;
    x = CMP_W'(v);
    if (x == '0) begin
      e = CMP_W'(1);
    end else if (x > CMP_W'(MAX_EXTENT)) begin
      e = CMP_W'(MAX_EXTENT);
    end else begin
      e = x;
    end
    return e[EXT_W-1:0];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      extent_x    <= vbi_pkg::CFG_W'(1);
      extent_y    <= vbi_pkg::CFG_W'(1);
      extent_z    <= vbi_pkg::CFG_W'(1);
      border_mode <= vbi_pkg::MODE_CLAMP;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        vbi_pkg::REG_EXTENT_X:    extent_x    <= cfg_wr_data;
        vbi_pkg::REG_EXTENT_Y:    extent_y    <= cfg_wr_data;
        vbi_pkg::REG_EXTENT_Z:    extent_z    <= cfg_wr_data;
        vbi_pkg::REG_BORDER_MODE: border_mode <= vbi_pkg::mode_t'(cfg_wr_data[1:0]);
        default: ;
      endcase
    end
  end

  // Axis order throughout: slice, row, column.
  assign ext_ax[0] = eff_extent(extent_z);
  assign ext_ax[1] = eff_extent(extent_y);
  assign ext_ax[2] = eff_extent(extent_x);
  assign raw_ax[0] = in_data.slice_coord;
  assign raw_ax[1] = in_data.row_coord;
  assign raw_ax[2] = in_data.col_coord;

  // The slice product is first used several stages in, well after any
  // configuration write has settled.
  always_ff @(posedge clk) begin
    area <= AREA_W'(ext_ax[2]) * AREA_W'(ext_ax[1]);
  end

  // Each stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[NST-1] = ~vld[NST-1] | out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = ~vld[i] | en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    vbi_axis_prep #(
      .MAX_EXTENT (MAX_EXTENT),
      .COORD_BITS (COORD_BITS)
    ) u_prep (
      .clk   (clk),
      .en    (en[0]),
      .raw   (raw_ax[a]),
      .ext   (ext_ax[a]),
      .mode  (border_mode),
      .mag   (prep_mag[a]),
      .neg   (prep_neg[a]),
      .alt   (prep_alt[a]),
      .fault (prep_fault[a])
    );

    assign rem_s[a][0]  = '0;
    assign mag_s[a][0]  = PAD_W'(prep_mag[a]);
    assign side_s[a][0] = {prep_fault[a], prep_neg[a], prep_alt[a]};

    for (genvar k = 0; k < NSTG; k++) begin : g_mod
      vbi_mod_stage #(
        .EXT_W  (EXT_W),
        .MAG_W  (PAD_W),
        .STEP   (STEP),
        .SIDE_W (SIDE_W)
      ) u_mod (
        .clk      (clk),
        .en       (en[k+1]),
        .ext      (ext_ax[a]),
        .rem_in   (rem_s[a][k]),
        .mag_in   (mag_s[a][k]),
        .side_in  (side_s[a][k]),
        .rem_out  (rem_s[a][k+1]),
        .mag_out  (mag_s[a][k+1]),
        .side_out (side_s[a][k+1])
      );
    end
  end

  // Wrap of a negative coordinate folds a non-zero remainder back from the extent; other modes pass the prep result.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = ext_ax[a] - rem_s[a][NSTG];
      if (border_mode == vbi_pkg::MODE_WRAP) begin
        if (side_s[a][NSTG][IDX_W] && (rem_s[a][NSTG] != '0)) begin
          sel_val[a] = diff[a][IDX_W-1:0];
        end else begin
          sel_val[a] = rem_s[a][NSTG][IDX_W-1:0];
        end
      end else begin
        sel_val[a] = side_s[a][NSTG][IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_SEL]) begin
      for (int a = 0; a < 3; a++) begin
        sel_c[a] <= sel_val[a];
      end
      sel_f <= side_s[0][NSTG][IDX_W+1] | side_s[1][NSTG][IDX_W+1]
             | side_s[2][NSTG][IDX_W+1];
    end
  end

  vbi_index #(
    .MAX_EXTENT (MAX_EXTENT)
  ) u_index (
    .clk      (clk),
    .en_mul   (en[S_MUL]),
    .en_sum   (en[S_SUM]),
    .c        (sel_c[2]),
    .r        (sel_c[1]),
    .s        (sel_c[0]),
    .ex       (ext_ax[2]),
    .area     (area),
    .fault_in (sel_f),
    .result   (out_data)
  );

endmodule

FILE: rtl/vbi_axis_prep.sv
// First pipeline stage for one axis: coordinate decode, clamp and mirror results,
// and the magnitude that feeds the wrap remainder chain.
// Depends on vbi_pkg.
module vbi_axis_prep #(
  parameter int MAX_EXTENT = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [vbi_pkg::COORD_W-1:0]             raw,
  input  logic [$clog2(MAX_EXTENT+1)-1:0]         ext,
  input  vbi_pkg::mode_t                          mode,
  output logic [COORD_BITS-1:0]                   mag,
  output logic                                    neg,
  output logic [$clog2(MAX_EXTENT)-1:0]           alt,
  output logic                                    fault
);

  localparam int EXT_W = $clog2(MAX_EXTENT + 1);
  localparam int IDX_W = $clog2(MAX_EXTENT);
  localparam int RAW_W = (COORD_BITS > vbi_pkg::COORD_W) ? COORD_BITS : vbi_pkg::COORD_W;
  localparam int W     = ((COORD_BITS > EXT_W + 1) ? COORD_BITS : EXT_W + 1) + 2;

  logic [RAW_W-1:0]             raw_ext;
  logic signed [COORD_BITS-1:0] cval;
  logic signed [W-1:0]          cw, ew, emax, clamp_v, mir, mir_cl, mag_w, alt_w;
  logic                         is_neg, over, mir_lo, mir_hi, fault_w;

  always_comb begin
    raw_ext = RAW_W'(raw);
    cval    = raw_ext[COORD_BITS-1:0];
    cw      = W'(cval);
    ew      = W'({1'b0, ext});
    emax    = ew - W'(1);
    is_neg  = cw[W-1];
    over    = (cw >= ew);

    clamp_v = is_neg ? '0 : (over ? emax : cw);

    // Mirror reflects once; a far overshoot is still outside and gets clamped.
    mir    = is_neg ? ~cw : (over ? (emax + ew - cw) : cw);
    mir_lo = mir[W-1];
    mir_hi = (mir >= ew);
    mir_cl = mir_lo ? '0 : (mir_hi ? emax : mir);

    mag_w  = is_neg ? -cw : cw;

    unique case (mode)
      vbi_pkg::MODE_CLAMP: begin
        alt_w   = clamp_v;
        fault_w = 1'b0;
      end
      vbi_pkg::MODE_MIRROR: begin
        alt_w   = mir_cl;
        fault_w = mir_lo | mir_hi;
      end
      vbi_pkg::MODE_WRAP: begin
        alt_w   = '0;
        fault_w = 1'b0;
      end
      default: begin
        alt_w   = clamp_v;
        fault_w = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag   <= mag_w[COORD_BITS-1:0];
      neg   <= is_neg;
      alt   <= alt_w[IDX_W-1:0];
      fault <= fault_w;
    end
  end

endmodule

FILE: rtl/vbi_mod_stage.sv
// One stage of the pipelined remainder unit: STEP restoring steps of
// magnitude modulo extent, with side data carried alongside.
// No package dependencies.
module vbi_mod_stage #(
  parameter int EXT_W  = 11,
  parameter int MAG_W  = 16,
  parameter int STEP   = 4,
  parameter int SIDE_W = 12
) (
  input  logic              clk,
  input  logic              en,
  input  logic [EXT_W-1:0]  ext,
  input  logic [EXT_W-1:0]  rem_in,
  input  logic [MAG_W-1:0]  mag_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic [EXT_W-1:0]  rem_out,
  output logic [MAG_W-1:0]  mag_out,
  output logic [SIDE_W-1:0] side_out
);

  logic [EXT_W-1:0] r;
  logic [MAG_W-1:0] m;
  logic [EXT_W:0]   t;

  always_comb begin
    r = rem_in;
    m = mag_in;
    t = '0;
    for (int k = 0; k < STEP; k++) begin
      t = {r, m[MAG_W-1]};
      m = {m[MAG_W-2:0], 1'b0};
      if (t >= {1'b0, ext}) begin
        t = t - {1'b0, ext};
      end
      r = t[EXT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= r;
      mag_out  <= m;
      side_out <= side_in;
    end
  end

endmodule

FILE: rtl/vbi_index.sv
// Last two pipeline stages: the partial products of the linear index,
// then their sum into the output register.
// Depends on vbi_pkg.
module vbi_index #(
  parameter int MAX_EXTENT = 1024
) (
  input  logic                                clk,
  input  logic                                en_mul,
  input  logic                                en_sum,
  input  logic [$clog2(MAX_EXTENT)-1:0]       c,
  input  logic [$clog2(MAX_EXTENT)-1:0]       r,
  input  logic [$clog2(MAX_EXTENT)-1:0]       s,
  input  logic [$clog2(MAX_EXTENT+1)-1:0]     ex,
  input  logic [2*$clog2(MAX_EXTENT+1)-1:0]   area,
  input  logic                                fault_in,
  output vbi_pkg::result_t                    result
);

  localparam int EXT_W  = $clog2(MAX_EXTENT + 1);
  localparam int IDX_W  = $clog2(MAX_EXTENT);
  localparam int AREA_W = 2 * EXT_W;
  localparam int PR_W   = IDX_W + EXT_W;
  localparam int PS_W   = IDX_W + AREA_W;
  localparam int SUM_W  = (PS_W + 2 > vbi_pkg::INDEX_W) ? PS_W + 2 : vbi_pkg::INDEX_W;

  logic [IDX_W-1:0] c_q;
  logic [PR_W-1:0]  pr_q;
  logic [PS_W-1:0]  ps_q;
  logic             f_q;
  logic [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      c_q  <= c;
      pr_q <= PR_W'(r) * PR_W'(ex);
      ps_q <= PS_W'(s) * PS_W'(area);
      f_q  <= fault_in;
    end
  end

  assign sum = SUM_W'(c_q) + SUM_W'(pr_q) + SUM_W'(ps_q);

  always_ff @(posedge clk) begin
    if (en_sum) begin
      result.linear_index <= sum[vbi_pkg::INDEX_W-1:0];
      result.fault        <= f_q;
    end
  end

endmodule

FILE: rtl/vbi_checker.sv
// Port-level checks for volume_border_index, attached by the bind below.
// Depends on vbi_pkg.
module vbi_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input vbi_pkg::result_t out_data
);

  // A result beat that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // With the output register free, the whole pipeline can move.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while the output side takes beats");

endmodule

bind volume_border_index vbi_checker u_vbi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
